/* hw/rtl/dksr_pkg.sv */
// Shared types and constants for the Dirac kinetic spinor rotation core.
// Holds the channel payload structs, the queue entry and the fixed-point constants.
// No dependencies.
package dksr_pkg;

  // Input request: spinor in Q1.15 and wave vector in Q3.12.
  typedef struct packed {
    logic signed [15:0] comp0_re;
    logic signed [15:0] comp0_im;
    logic signed [15:0] comp1_re;
    logic signed [15:0] comp1_im;
    logic signed [15:0] comp2_re;
    logic signed [15:0] comp2_im;
    logic signed [15:0] comp3_re;
    logic signed [15:0] comp3_im;
    logic signed [15:0] wave_x;
    logic signed [15:0] wave_y;
    logic signed [15:0] wave_z;
  } dksr_in_t;

  // Result request: rotated spinor in Q1.15.
  typedef struct packed {
    logic signed [15:0] out0_re;
    logic signed [15:0] out0_im;
    logic signed [15:0] out1_re;
    logic signed [15:0] out1_im;
    logic signed [15:0] out2_re;
    logic signed [15:0] out2_im;
    logic signed [15:0] out3_re;
    logic signed [15:0] out3_im;
  } dksr_out_t;

  typedef logic [15:0] word_t;

  // Classified request as it sits in the queue between front and back.
  typedef struct packed {
    word_t [7:0] spin;   // index 2*n is component n real, 2*n+1 imaginary
    word_t [2:0] wave;   // index 0 is x, 1 is y, 2 is z
    logic [31:0] ksq;    // |k|^2 in Q8.24
    logic        zero;   // wave vector is exactly zero
  } dksr_item_t;

  localparam int QUEUE_DEPTH = 4;
  localparam logic [15:0] TIME_STEP_RESET = 16'd8192;

  // Pipeline lengths set by the fixed operand widths.
  localparam int SQ_STEPS  = 24;  // one root bit per stage
  localparam int DIV_STEPS = 31;  // one quotient bit per stage
  localparam int SC_STAGES = 12;  // phase and sine/cosine lane
  localparam int DLY_STAGES = DIV_STEPS - SC_STAGES;

  localparam logic [27:0] INV_PI_K    = 28'd170891319;   // round(2^29/pi)
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;  // pi/2 in Q30
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  // Series divisors, innermost first, and their reciprocals in Q30.
  localparam logic [6:0] SIN_DIV [4] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0] COS_DIV [4] = '{7'd90, 7'd56, 7'd30, 7'd12};
  localparam logic [27:0] SIN_RCP [4] = '{
    28'((64'd1 << 30) / 64'd72), 28'((64'd1 << 30) / 64'd42),
    28'((64'd1 << 30) / 64'd20), 28'((64'd1 << 30) / 64'd6)};
  localparam logic [27:0] COS_RCP [4] = '{
    28'((64'd1 << 30) / 64'd90), 28'((64'd1 << 30) / 64'd56),
    28'((64'd1 << 30) / 64'd30), 28'((64'd1 << 30) / 64'd12)};

endpackage

/* hw/rtl/dksr_front.sv */
// Front end: accepts input requests, squares the wave vector and flags zero k.
// Depends on dksr_pkg.
module dksr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dksr_pkg::dksr_in_t   in_data,
  output logic                 item_vld,
  input  logic                 item_rdy,
  output dksr_pkg::dksr_item_t item
);
  import dksr_pkg::*;

  logic       vld_r;
  dksr_item_t item_r, item_nxt;
  logic signed [31:0] sq_x, sq_y, sq_z;

  assign in_ready = !vld_r || item_rdy;
  assign item_vld = vld_r;
  assign item     = item_r;

  // Square magnitude and zero test of the wave vector.
  always_comb begin
    sq_x = in_data.wave_x * in_data.wave_x;
    sq_y = in_data.wave_y * in_data.wave_y;
    sq_z = in_data.wave_z * in_data.wave_z;
    item_nxt.spin[0] = in_data.comp0_re;
    item_nxt.spin[1] = in_data.comp0_im;
    item_nxt.spin[2] = in_data.comp1_re;
    item_nxt.spin[3] = in_data.comp1_im;
    item_nxt.spin[4] = in_data.comp2_re;
    item_nxt.spin[5] = in_data.comp2_im;
    item_nxt.spin[6] = in_data.comp3_re;
    item_nxt.spin[7] = in_data.comp3_im;
    item_nxt.wave[0] = in_data.wave_x;
    item_nxt.wave[1] = in_data.wave_y;
    item_nxt.wave[2] = in_data.wave_z;
    item_nxt.ksq  = 32'(sq_x) + 32'(sq_y) + 32'(sq_z);
    item_nxt.zero = (item_nxt.ksq == 32'd0);
  end

  // Holding register toward the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

/* hw/rtl/dksr_queue.sv */
// Short queue between the front end and the arithmetic back end.
// Depends on dksr_pkg.
module dksr_queue #(
  parameter int DEPTH = dksr_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_vld,
  output logic                 push_rdy,
  input  dksr_pkg::dksr_item_t push_item,
  output logic                 head_vld,
  input  logic                 pop,
  output dksr_pkg::dksr_item_t head_item
);
  import dksr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dksr_item_t      mem_r [DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign push_rdy  = (cnt_r != CW'(DEPTH));
  assign head_vld  = (cnt_r != '0);
  assign head_item = mem_r[rd_r];
  assign do_push   = push_vld && push_rdy;
  assign do_pop    = pop && head_vld;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

/* hw/rtl/dksr_back.sv */
// Back end: square root, direction divide, phase sine/cosine, alpha product
// and rounding. All stages advance together, one request per cycle unless the output stalls.
// Depends on dksr_pkg.
module dksr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          time_step,
  input  logic                 head_vld,
  input  dksr_pkg::dksr_item_t head_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dksr_pkg::dksr_out_t  out_data
);
  import dksr_pkg::*;

  typedef struct packed {
    logic        vld;
    logic        zero;
    word_t [7:0] spin;
    word_t [2:0] wave;
    logic [47:0] rad;
    logic [26:0] rem;
    logic [23:0] root;
  } sq_t;

  typedef struct packed {
    logic             vld;
    logic             zero;
    word_t [7:0]      spin;
    logic [2:0]       neg;
    logic [23:0]      mag;
    logic [2:0][25:0] rem;
    logic [2:0][30:0] quo;
  } dv_t;

  typedef struct packed {
    logic [2:0]       oct;
    logic [29:0]      x;
    logic [28:0]      q2;
    logic [3:0][27:0] qs;
    logic [3:0][27:0] qc;
    logic [30:0]      ts;
    logic [30:0]      tc;
  } hn_t;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } sc_t;

  logic en;
  logic out_vld_r;

  // Every stage moves unless a finished result is held at the output.
  assign en        = !out_vld_r || out_ready;
  assign pop       = en && head_vld;
  assign out_valid = out_vld_r;

  // ---------------- Square root, one root bit per stage ----------------
  sq_t sq_r [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    sq_t         cur, st_nxt;
    logic [26:0] sh, tr;
    if (j == 0) begin : g_first
      always_comb begin
        cur.vld  = head_vld;
        cur.zero = head_item.zero;
        cur.spin = head_item.spin;
        cur.wave = head_item.wave;
        cur.rad  = {head_item.ksq, 16'd0};
        cur.rem  = '0;
        cur.root = '0;
      end
    end else begin : g_rest
      assign cur = sq_r[j-1];
    end
    // Restoring step on the next pair of radicand bits.
    always_comb begin
      st_nxt = cur;
      sh = {cur.rem[24:0], cur.rad[2*(SQ_STEPS-1-j) +: 2]};
      tr = {1'b0, cur.root, 2'b01};
      if (sh >= tr) begin
        st_nxt.rem  = sh - tr;
        st_nxt.root = {cur.root[22:0], 1'b1};
      end else begin
        st_nxt.rem  = sh;
        st_nxt.root = {cur.root[22:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[j].vld <= 1'b0;
      end else if (en) begin
        sq_r[j] <= st_nxt;
      end
    end
  end

  // ---------------- Direction divide, one quotient bit per stage ----------------
  dv_t dv_r [DIV_STEPS];
  logic [23:0] mag;
  assign mag = sq_r[SQ_STEPS-1].root;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
    dv_t cur, st_nxt;
    logic [2:0][25:0] sh;
    if (j == 0) begin : g_first
      always_comb begin
        cur.vld  = sq_r[SQ_STEPS-1].vld;
        cur.zero = sq_r[SQ_STEPS-1].zero;
        cur.spin = sq_r[SQ_STEPS-1].spin;
        cur.mag  = mag;
        cur.quo  = '0;
        for (int c = 0; c < 3; c++) begin
          cur.neg[c] = sq_r[SQ_STEPS-1].wave[c][15];
          cur.rem[c] = {3'b000,
                        (cur.neg[c] ? 16'(-sq_r[SQ_STEPS-1].wave[c])
                                    : sq_r[SQ_STEPS-1].wave[c]),
                        7'd0};
        end
      end
    end else begin : g_rest
      assign cur = dv_r[j-1];
    end
    // Shift-and-subtract for each of the three components.
    always_comb begin
      st_nxt = cur;
      for (int c = 0; c < 3; c++) begin
        sh[c] = {cur.rem[c][24:0], 1'b0};
        if (sh[c] >= {2'b00, cur.mag}) begin
          st_nxt.rem[c] = sh[c] - {2'b00, cur.mag};
          st_nxt.quo[c] = {cur.quo[c][29:0], 1'b1};
        end else begin
          st_nxt.rem[c] = sh[c];
          st_nxt.quo[c] = {cur.quo[c][29:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j].vld <= 1'b0;
      end else if (en) begin
        dv_r[j] <= st_nxt;
      end
    end
  end

  // ---------------- Phase and sine/cosine lane ----------------
  logic [39:0] ph_r;
  logic [45:0] php_lo_r, php_hi_r;
  logic [2:0]  oct3_r;
  logic [29:0] rr3_r;
  logic [2:0]  oct4_r;
  logic [29:0] x4_r;
  logic [2:0]  oct5_r;
  logic [29:0] x5_r, x25_r;
  logic [2:0]  oct6_r;
  logic [29:0] x6_r, x26_r;
  logic [3:0][27:0] qes6_r, qec6_r;
  hn_t         hn_r [4];
  logic [2:0]  oct11_r;
  logic [30:0] s0_r, c0_r;
  sc_t         sc_r;
  sc_t         dl_r [DLY_STAGES];

  logic [35:0] phs;
  logic [63:0] phsum;
  logic [31:0] ang;
  logic [29:0] rr;
  logic [60:0] xp;
  logic [59:0] x2p;
  hn_t         hn0;
  logic [60:0] s0p;
  logic [59:0] c0p;
  sc_t         sc_nxt;

  // Phase in Q30 radians, then scaled to turns in two half-width products.
  assign phs = ph_r[39:4];
  always_ff @(posedge clk) begin
    if (en) begin
      ph_r     <= {16'd0, mag} * {24'd0, time_step};
      php_lo_r <= {28'd0, phs[17:0]} * {18'd0, INV_PI_K};
      php_hi_r <= {28'd0, phs[35:18]} * {18'd0, INV_PI_K};
    end
  end

  // Octant split and mirror of the residual in odd octants.
  always_comb begin
    phsum = {php_hi_r, 18'd0} + {18'd0, php_lo_r};
    ang   = phsum[59:28];
    rr    = ang[29] ? (30'h2000_0000 - {1'b0, ang[28:0]}) : {1'b0, ang[28:0]};
    xp    = {31'd0, rr3_r} * {30'd0, HALF_PI_Q30};
    x2p   = {30'd0, x4_r} * {30'd0, x4_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oct3_r <= ang[31:29];
      rr3_r  <= rr;
      oct4_r <= oct3_r;
      x4_r   <= xp[59:30];
      oct5_r <= oct4_r;
      x5_r   <= x4_r;
      x25_r  <= x2p[59:30];
    end
  end

  // Estimated quotients of x^2 by the series divisors.
  always_ff @(posedge clk) begin
    if (en) begin
      oct6_r <= oct5_r;
      x6_r   <= x5_r;
      x26_r  <= x25_r;
      for (int i = 0; i < 4; i++) begin
        qes6_r[i] <= 28'((58'(x25_r) * 58'(SIN_RCP[i])) >> 30);
        qec6_r[i] <= 28'((58'(x25_r) * 58'(COS_RCP[i])) >> 30);
      end
    end
  end

  // Quotient correction: the estimate is at most one low.
  always_comb begin
    logic [29:0] rs, rc;
    hn0.oct = oct6_r;
    hn0.x   = x6_r;
    hn0.q2  = x26_r[29:1];
    hn0.ts  = '0;
    hn0.tc  = '0;
    for (int i = 0; i < 4; i++) begin
      rs = x26_r - 30'(35'(qes6_r[i]) * 35'(SIN_DIV[i]));
      rc = x26_r - 30'(35'(qec6_r[i]) * 35'(COS_DIV[i]));
      hn0.qs[i] = (rs >= 30'(SIN_DIV[i])) ? qes6_r[i] + 1'b1 : qes6_r[i];
      hn0.qc[i] = (rc >= 30'(COS_DIV[i])) ? qec6_r[i] + 1'b1 : qec6_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hn_r[0] <= hn0;
    end
  end

  // Horner steps of the sine and cosine series, one term per stage.
  for (genvar h = 1; h < 4; h++) begin : g_hn
    hn_t         st_nxt;
    logic [30:0] tps, tpc;
    logic [58:0] ms, mc;
    always_comb begin
      st_nxt = hn_r[h-1];
      if (h == 1) begin
        tps = ONE_Q30 - 31'(hn_r[h-1].qs[0]);
        tpc = ONE_Q30 - 31'(hn_r[h-1].qc[0]);
      end else begin
        tps = hn_r[h-1].ts;
        tpc = hn_r[h-1].tc;
      end
      ms = 59'(hn_r[h-1].qs[h]) * 59'(tps);
      mc = 59'(hn_r[h-1].qc[h]) * 59'(tpc);
      st_nxt.ts = ONE_Q30 - 31'(ms[58:30]);
      st_nxt.tc = ONE_Q30 - 31'(mc[58:30]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        hn_r[h] <= st_nxt;
      end
    end
  end

  // Closing series terms.
  always_comb begin
    s0p = 61'(hn_r[3].x) * 61'(hn_r[3].ts);
    c0p = 60'(hn_r[3].q2) * 60'(hn_r[3].tc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oct11_r <= hn_r[3].oct;
      s0_r    <= s0p[60:30];
      c0_r    <= ONE_Q30 - 31'(c0p[59:30]);
    end
  end

  // Octant symmetry.
  always_comb begin
    logic signed [31:0] ps, pc;
    ps = $signed({1'b0, s0_r});
    pc = $signed({1'b0, c0_r});
    case (oct11_r)
      3'd0:    begin sc_nxt.s = ps;  sc_nxt.c = pc;  end
      3'd1:    begin sc_nxt.s = pc;  sc_nxt.c = ps;  end
      3'd2:    begin sc_nxt.s = pc;  sc_nxt.c = -ps; end
      3'd3:    begin sc_nxt.s = ps;  sc_nxt.c = -pc; end
      3'd4:    begin sc_nxt.s = -ps; sc_nxt.c = -pc; end
      3'd5:    begin sc_nxt.s = -pc; sc_nxt.c = -ps; end
      3'd6:    begin sc_nxt.s = -pc; sc_nxt.c = ps;  end
      default: begin sc_nxt.s = -ps; sc_nxt.c = pc;  end
    endcase
  end

  // Align sine/cosine with the end of the divide.
  always_ff @(posedge clk) begin
    if (en) begin
      sc_r     <= sc_nxt;
      dl_r[0]  <= sc_r;
      for (int d = 1; d < DLY_STAGES; d++) begin
        dl_r[d] <= dl_r[d-1];
      end
    end
  end

  // ---------------- Alpha product and output rounding ----------------
  dv_t                lst;
  logic signed [31:0] ux [3];
  logic               e1_vld_r, e2_vld_r, e3_vld_r;
  logic               e1_zero_r, e2_zero_r, e3_zero_r;
  word_t [7:0]        e1_spin_r, e2_spin_r, e3_spin_r;
  sc_t                e1_sc_r, e2_sc_r;
  logic signed [47:0] e1_prod_r [3][8];
  logic signed [34:0] e2_ar_r [8];
  logic signed [47:0] e3_m1_r [8];
  logic signed [67:0] e3_m2_r [8];
  logic signed [49:0] asum [8];
  logic signed [49:0] arnd [8];
  dksr_out_t          out_r;
  word_t [7:0]        ow;

  assign lst = dv_r[DIV_STEPS-1];

  // Signed direction cosines in Q30.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ux[c] = lst.neg[c] ? -$signed({1'b0, lst.quo[c]}) : $signed({1'b0, lst.quo[c]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
      e2_vld_r <= 1'b0;
      e3_vld_r <= 1'b0;
    end else if (en) begin
      e1_vld_r <= lst.vld;
      e2_vld_r <= e1_vld_r;
      e3_vld_r <= e2_vld_r;
    end
  end

  // Products of each direction cosine with each spinor part.
  always_ff @(posedge clk) begin
    if (en) begin
      e1_zero_r <= lst.zero;
      e1_spin_r <= lst.spin;
      e1_sc_r   <= dl_r[DLY_STAGES-1];
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 8; j++) begin
          e1_prod_r[c][j] <= ux[c] * $signed(lst.spin[j]);
        end
      end
    end
  end

  // Alpha matrix rows, then rounding from Q45 to Q30.
  always_comb begin
    for (int h = 0; h < 2; h++) begin
      int b;
      b = (h == 0) ? 4 : 0;
      asum[4*h+0] = e1_prod_r[2][b]   + e1_prod_r[0][b+2] + e1_prod_r[1][b+3];
      asum[4*h+1] = e1_prod_r[2][b+1] + e1_prod_r[0][b+3] - e1_prod_r[1][b+2];
      asum[4*h+2] = e1_prod_r[0][b]   - e1_prod_r[1][b+1] - e1_prod_r[2][b+2];
      asum[4*h+3] = e1_prod_r[0][b+1] + e1_prod_r[1][b]   - e1_prod_r[2][b+3];
    end
    for (int i = 0; i < 8; i++) begin
      arnd[i] = (asum[i] + 50'sd16384) >>> 15;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_zero_r <= e1_zero_r;
      e2_spin_r <= e1_spin_r;
      e2_sc_r   <= e1_sc_r;
      for (int i = 0; i < 8; i++) begin
        e2_ar_r[i] <= arnd[i][34:0];
      end
    end
  end

  // Cosine and sine terms of each output part.
  always_ff @(posedge clk) begin
    if (en) begin
      e3_zero_r <= e2_zero_r;
      e3_spin_r <= e2_spin_r;
      for (int i = 0; i < 8; i++) begin
        logic signed [67:0] sp;
        e3_m1_r[i] <= e2_sc_r.c * $signed(e2_spin_r[i]);
        if (i % 2 == 0) begin
          sp = e2_sc_r.s * e2_ar_r[i+1];
          e3_m2_r[i] <= sp;
        end else begin
          sp = e2_sc_r.s * e2_ar_r[i-1];
          e3_m2_r[i] <= -sp;
        end
      end
    end
  end

  // Final rounding and saturation to Q1.15; zero k passes the spinor.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      logic signed [69:0] tot, rsh;
      tot = (70'(e3_m1_r[i]) <<< 15) + 70'(e3_m2_r[i]) + (70'sd1 <<< 44);
      rsh = tot >>> 45;
      if (e3_zero_r) begin
        ow[i] = e3_spin_r[i];
      end else if (rsh > 70'sd32767) begin
        ow[i] = 16'h7FFF;
      end else if (rsh < -70'sd32768) begin
        ow[i] = 16'h8000;
      end else begin
        ow[i] = rsh[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= e3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.out0_re <= ow[0];
      out_r.out0_im <= ow[1];
      out_r.out1_re <= ow[2];
      out_r.out1_im <= ow[3];
      out_r.out2_re <= ow[4];
      out_r.out2_im <= ow[5];
      out_r.out3_re <= ow[6];
      out_r.out3_im <= ow[7];
    end
  end

  assign out_data = out_r;

endmodule

/* hw/rtl/dirac_kinetic_spinor_rotation_core.sv */
// Dirac kinetic propagator for one momentum point.
// Input channel (in_valid/in_ready/in_data): one request per momentum point, carrying
// a four-component Q1.15 spinor and a Q3.12 wave vector.
// Result channel (out_valid/out_ready/out_data): the spinor rotated by
// exp(-i alpha.k dt), rounded and saturated to Q1.15; a zero wave vector passes through.
// Configuration channel (cfg_valid/cfg_ready/cfg_data): writes the Q2.14 time step; always
// ready. The user must write it only while the block is idle; the block does not enforce it.
// Throughput: one request per cycle while no result waits at the output. A request runs
// from the front register through the queue, the 24-stage root pipeline, the 31-stage
// direction divide and the four product and rounding stages behind it to out_valid.
// A front register classifies requests into a four-entry queue; the back pipeline
// pulls from that queue and stops as a whole while a result waits at the output,
// so in_ready stays high until the queue and the front register are both full.
// Reset clears all valid state and sets the time step to 8192 (0.5).
// Depends on dksr_pkg, dksr_front, dksr_queue and dksr_back.
module dirac_kinetic_spinor_rotation_core #(
  parameter int QUEUE_DEPTH = dksr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dksr_pkg::dksr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dksr_pkg::dksr_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import dksr_pkg::*;

  logic [15:0] time_step_r;
  logic        fq_vld, fq_rdy;
  dksr_item_t  fq_item;
  logic        head_vld, pop;
  dksr_item_t  head_item;

  // Time step register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      time_step_r <= cfg_data;
    end
  end

  dksr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .item_vld (fq_vld),
    .item_rdy (fq_rdy),
    .item     (fq_item)
  );

  dksr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (fq_vld),
    .push_rdy  (fq_rdy),
    .push_item (fq_item),
    .head_vld  (head_vld),
    .pop       (pop),
    .head_item (head_item)
  );

  dksr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .time_step (time_step_r),
    .head_vld  (head_vld),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/dksr_checker.sv */
// Port-level checks for the Dirac kinetic spinor rotation core, bound to the top level.
// Depends on dksr_pkg and dirac_kinetic_spinor_rotation_core.
module dksr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input dksr_pkg::dksr_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input dksr_pkg::dksr_out_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [15:0]         cfg_data
);

  // A stalled result request holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Back pressure on the input only builds up through accepted requests.
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("in_ready dropped without an accepted request");

  // The time step register takes every write at once.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind dirac_kinetic_spinor_rotation_core dksr_checker u_dksr_checker (.*);

/* verif/dirac_kinetic_spinor_rotation_core_tb.sv */
// Self-checking testbench for the Dirac kinetic spinor rotation core.
// Predicts each rotated spinor in fixed point and checks it field by field.
// Depends on dksr_pkg and dirac_kinetic_spinor_rotation_core.
`timescale 1ns / 1ps

module dirac_kinetic_spinor_rotation_core_tb;
  import dksr_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  dksr_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  dksr_out_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [15:0] cfg_data;

  dirac_kinetic_spinor_rotation_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  localparam int LATENCY_WAIT = 120;
  localparam int RANDOM_PER_PHASE = 180;

  dksr_in_t  point_q[$];     // requests waiting to be sent
  dksr_out_t rotated_q[$];   // predicted rotations, oldest first
  logic [15:0] step_now;     // time step the core currently holds
  int        mismatches;
  logic      drain_hold;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root, bit by bit.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Sine and cosine in Q30 of an angle given in units of 2^-32 turn.
  function automatic void turn_sin_cos(input logic [31:0] ang, output longint sn,
                                       output longint cs);
    logic [2:0] oct;
    longint unsigned r, x, x2, t;
    longint s0, c0;
    oct = ang[31:29];
    r = ang[28:0];
    if (oct[0]) r = (64'd1 << 29) - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t = (64'd1 << 30) - x2 / 72;
    t = (64'd1 << 30) - (((x2 / 42) * t) >> 30);
    t = (64'd1 << 30) - (((x2 / 20) * t) >> 30);
    t = (64'd1 << 30) - (((x2 / 6) * t) >> 30);
    s0 = longint'((x * t) >> 30);
    t = (64'd1 << 30) - x2 / 90;
    t = (64'd1 << 30) - (((x2 / 56) * t) >> 30);
    t = (64'd1 << 30) - (((x2 / 30) * t) >> 30);
    t = (64'd1 << 30) - (((x2 / 12) * t) >> 30);
    c0 = longint'(64'd1 << 30) - longint'(((x2 / 2) * t) >> 30);
    // Fold the octant back onto the first one.
    case (oct)
      3'd0: begin sn = s0;  cs = c0;  end
      3'd1: begin sn = c0;  cs = s0;  end
      3'd2: begin sn = c0;  cs = -s0; end
      3'd3: begin sn = s0;  cs = -c0; end
      3'd4: begin sn = -s0; cs = -c0; end
      3'd5: begin sn = -c0; cs = -s0; end
      3'd6: begin sn = -c0; cs = s0;  end
      default: begin sn = -s0; cs = c0; end
    endcase
  endfunction

  // Round half up after dropping sh bits, then clamp to Q1.15.
  function automatic logic [15:0] round_clamp(input longint v, input int sh);
    longint w;
    w = (v + (longint'(1) << (sh - 1))) >>> sh;
    if (w > 32767) w = 32767;
    if (w < -32768) w = -32768;
    return w[15:0];
  endfunction

  // Expected rotated spinor for one momentum point.
  function automatic dksr_out_t rotate_spinor(input dksr_in_t d, input logic [15:0] dt);
    longint p[8];
    longint a[8];
    longint kx, ky, kz, ux, uy, uz, sn, cs, are, aim;
    longint unsigned ksq, mag, ph;
    logic [31:0] ang;
    logic [127:0] res;
    p[0] = d.comp0_re; p[1] = d.comp0_im; p[2] = d.comp1_re; p[3] = d.comp1_im;
    p[4] = d.comp2_re; p[5] = d.comp2_im; p[6] = d.comp3_re; p[7] = d.comp3_im;
    kx = d.wave_x; ky = d.wave_y; kz = d.wave_z;
    ksq = longint'(kx * kx + ky * ky + kz * kz);
    // A zero wave vector passes the spinor through.
    if (ksq == 0) begin
      for (int i = 0; i < 8; i++) res[127 - 16 * i -: 16] = p[i][15:0];
      return dksr_out_t'(res);
    end
    mag = int_sqrt(ksq << 16);
    ux = (kx * (longint'(1) << 38)) / longint'(mag);
    uy = (ky * (longint'(1) << 38)) / longint'(mag);
    uz = (kz * (longint'(1) << 38)) / longint'(mag);
    ph = (mag * dt) >> 4;
    ang = 32'((ph * 64'd170891319) >> 28);
    turn_sin_cos(ang, sn, cs);
    a[0] = uz * p[4] + ux * p[6] + uy * p[7];
    a[1] = uz * p[5] + ux * p[7] - uy * p[6];
    a[2] = ux * p[4] - uy * p[5] - uz * p[6];
    a[3] = ux * p[5] + uy * p[4] - uz * p[7];
    a[4] = uz * p[0] + ux * p[2] + uy * p[3];
    a[5] = uz * p[1] + ux * p[3] - uy * p[2];
    a[6] = ux * p[0] - uy * p[1] - uz * p[2];
    a[7] = ux * p[1] + uy * p[0] - uz * p[3];
    for (int i = 0; i < 4; i++) begin
      are = (a[2 * i] + (longint'(1) << 14)) >>> 15;
      aim = (a[2 * i + 1] + (longint'(1) << 14)) >>> 15;
      res[127 - 32 * i -: 16] = round_clamp(cs * p[2 * i] * 32768 + sn * aim, 45);
      res[111 - 32 * i -: 16] = round_clamp(cs * p[2 * i + 1] * 32768 - sn * are, 45);
    end
    return dksr_out_t'(res);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH %s at %0t", msg, $realtime);
    mismatches++;
  endtask

  // Driver: bursts of requests separated by random gaps.
  int burst_left, gap_left;
  always @(posedge clk) begin
    logic       nv;
    dksr_in_t   nd;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) rotated_q.push_back(rotate_spinor(in_data, step_now));
      nv = in_valid;
      nd = in_data;
      if (!in_valid || in_ready) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (point_q.size() != 0 && !drain_hold) begin
          nv = 1'b1;
          nd = point_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(40);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
          end
        end
      end
      in_valid <= nv;
      in_data <= nd;
    end
  end

  // Monitor: checks results and stalls on a changing pattern.
  string field_name[8] = '{"out0_re", "out0_im", "out1_re", "out1_im",
                           "out2_re", "out2_im", "out3_re", "out3_im"};
  int stall_mode, mode_left;
  always @(posedge clk) begin
    dksr_out_t want;
    logic      nr;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_mode = 0;
      mode_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (rotated_q.size() == 0) begin
          report_mismatch("unexpected result");
        end else begin
          want = rotated_q.pop_front();
          for (int i = 0; i < 8; i++)
            if (out_data[127 - 16 * i -: 16] !== want[127 - 16 * i -: 16])
              report_mismatch($sformatf("%s: got %0d expected %0d", field_name[i],
                                        $signed(out_data[127 - 16 * i -: 16]),
                                        $signed(want[127 - 16 * i -: 16])));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(3);
        mode_left = $urandom_range(200, 20);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: nr = 1'b1;
        1: nr = ($urandom_range(1) == 0);
        2: nr = ($urandom_range(7) == 0);
        default: nr = ((mode_left % 16) < 10);
      endcase
      out_ready <= nr;
    end
  end

  function automatic dksr_in_t make_point(input logic [15:0] c[8], input logic [15:0] kx,
                                          input logic [15:0] ky, input logic [15:0] kz);
    dksr_in_t d;
    d = '{c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], kx, ky, kz};
    return d;
  endfunction

  function automatic logic [15:0] pick_wave();
    case ($urandom_range(5))
      0: return 16'($urandom_range(15)) - 16'd8;
      1: return 16'h8000;
      2: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic dksr_in_t random_point();
    logic [15:0] c[8];
    for (int i = 0; i < 8; i++)
      case ($urandom_range(7))
        0: c[i] = 16'h8000;
        1: c[i] = 16'h7fff;
        default: c[i] = 16'($urandom);
      endcase
    if ($urandom_range(9) == 0) return make_point(c, 16'd0, 16'd0, 16'd0);
    return make_point(c, pick_wave(), pick_wave(), pick_wave());
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (point_q.size() != 0 || in_valid || rotated_q.size() != 0);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic write_time_step(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    step_now = v;
    cfg_valid <= 1'b0;
  endtask

  // Directed corners: zero wave vector, extremes of spinor and wave vector.
  task automatic load_directed();
    logic [15:0] lo[8], hi[8], mix[8];
    for (int i = 0; i < 8; i++) begin
      lo[i] = 16'h8000;
      hi[i] = 16'h7fff;
      mix[i] = i[0] ? 16'h8000 : 16'h7fff;
    end
    point_q.push_back(make_point(hi, 16'd0, 16'd0, 16'd0));
    point_q.push_back(make_point(lo, 16'd0, 16'd0, 16'd0));
    point_q.push_back(make_point(hi, 16'h7fff, 16'h7fff, 16'h7fff));
    point_q.push_back(make_point(lo, 16'h8000, 16'h8000, 16'h8000));
    point_q.push_back(make_point(mix, 16'h8000, 16'h7fff, 16'h8000));
    point_q.push_back(make_point(hi, 16'd1, 16'd0, 16'd0));
    point_q.push_back(make_point(lo, 16'd0, 16'hffff, 16'd0));
    point_q.push_back(make_point(mix, 16'd0, 16'd0, 16'd1));
    point_q.push_back(make_point(hi, 16'd4096, 16'd0, 16'd0));
    point_q.push_back(make_point(lo, 16'd0, 16'd4096, 16'hf000));
    point_q.push_back(make_point(mix, 16'h8000, 16'd0, 16'd0));
    point_q.push_back(make_point(hi, 16'd3, 16'd4, 16'd0));
    for (int i = 0; i < 6; i++) point_q.push_back(random_point());
  endtask

  // Stimulus and configuration phases.
  logic [15:0] step_plan[7] = '{16'd0, 16'd65535, 16'd1, 16'd8192, 16'd40000,
                                16'd3, 16'd20000};
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    drain_hold = 1'b0;
    mismatches = 0;
    step_now = TIME_STEP_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Reset value of the time step first.
    load_directed();
    for (int i = 0; i < RANDOM_PER_PHASE / 2; i++) point_q.push_back(random_point());
    wait_idle();
    for (int ph = 0; ph < 7; ph++) begin
      write_time_step(ph == 6 ? 16'($urandom) : step_plan[ph]);
      if (ph < 3) load_directed();
      for (int i = 0; i < RANDOM_PER_PHASE / 2; i++) point_q.push_back(random_point());
      if (ph == 4) begin
        // Hold the sender until every pending result has drained.
        while (point_q.size() > RANDOM_PER_PHASE / 4) @(posedge clk);
        drain_hold <= 1'b1;
        do @(posedge clk);
        while (in_valid || rotated_q.size() != 0);
        drain_hold <= 1'b0;
      end
      for (int i = 0; i < RANDOM_PER_PHASE / 2; i++) point_q.push_back(random_point());
      wait_idle();
    end
    if (mismatches == 0) begin
      $display("dirac_kinetic_spinor_rotation_core regression: pass");
    end else begin
      $display("dirac_kinetic_spinor_rotation_core regression: fail");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("dirac_kinetic_spinor_rotation_core regression: fail");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/dksr_pkg.sv
hw/rtl/dksr_front.sv
hw/rtl/dksr_queue.sv
hw/rtl/dksr_back.sv
hw/rtl/dirac_kinetic_spinor_rotation_core.sv
hw/rtl/dksr_checker.sv
verif/dirac_kinetic_spinor_rotation_core_tb.sv
